/* rtl/core/psfca_pkg.sv */
// Shared types and constants of the per-source frame count alarm.
package psfca_pkg;

  localparam int ADDR_W      = 48;
  localparam int THR_W       = 16;
  localparam int WL_USED_W   = 3;
  localparam int WL_REGS     = 4;
  localparam int OUT_COUNT_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int SLOT_MAX_W  = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_WL_USED   = 3'd1,
    REG_WL_A      = 3'd2,
    REG_WL_B      = 3'd3,
    REG_WL_C      = 3'd4,
    REG_WL_D      = 3'd5,
    REG_BEEP      = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CMD_WL_MISS,
    CMD_WL_HIT,
    CMD_HIT,
    CMD_INSERT,
    CMD_FULL
  } cmd_kind_e;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } back_state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]     addr;
    cmd_kind_e             kind;
    logic [SLOT_MAX_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]      addr;
    logic                   wl_hit;
    logic [OUT_COUNT_W-1:0] count;
    logic                   alarm;
    logic                   alert;
    logic                   new_entry;
    logic                   full;
  } res_t;

endpackage

/* rtl/core/psfca_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module psfca_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/psfca_front.sv */
// Front end: whitelist check, address table lookup and insertion.
module psfca_front
  import psfca_pkg::*;
#(
  parameter int TABLE_DEPTH     = 16,
  parameter int WHITELIST_SLOTS = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [ADDR_W-1:0]                addr_i,
  input  logic                             q_full_i,
  input  logic [WL_USED_W-1:0]             wl_used_i,
  input  logic [WL_REGS-1:0][ADDR_W-1:0]   wl_addr_i,
  output logic                             q_push_o,
  output cmd_t                             cmd_o
);

  localparam int SlotW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int FillW = $clog2(TABLE_DEPTH + 1);

  logic [ADDR_W-1:0]    entry_addr_q [TABLE_DEPTH];
  logic [FillW-1:0]     fill_q, fill_d;
  logic [TABLE_DEPTH-1:0] match;
  logic [SlotW-1:0]     hit_slot;
  logic                 wl_hit;
  logic                 accept;
  logic                 insert;

  // Whitelist slots beyond the supported count are never compared.
  always_comb begin
    wl_hit = 1'b0;
    for (int i = 0; i < WL_REGS; i++) begin
      if ((i < WHITELIST_SLOTS) && (WL_USED_W'(i) < wl_used_i) &&
          (wl_addr_i[i] == addr_i)) begin
        wl_hit = 1'b1;
      end
    end
  end

  // Stored addresses are unique, so at most one entry matches.
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (FillW'(i) < fill_q) && (entry_addr_q[i] == addr_i);
      if (match[i]) begin
        hit_slot = hit_slot | SlotW'(i);
      end
    end
  end

  always_comb begin
    cmd_o.addr = addr_i;
    cmd_o.slot = '0;
    if (wl_used_i != '0) begin
      cmd_o.kind = wl_hit ? CMD_WL_HIT : CMD_WL_MISS;
    end else if (|match) begin
      cmd_o.kind = CMD_HIT;
      cmd_o.slot = SLOT_MAX_W'(hit_slot);
    end else if (fill_q != FillW'(TABLE_DEPTH)) begin
      cmd_o.kind = CMD_INSERT;
      cmd_o.slot = SLOT_MAX_W'(fill_q);
    end else begin
      cmd_o.kind = CMD_FULL;
    end
  end

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;
  assign insert   = accept && (cmd_o.kind == CMD_INSERT);
  assign fill_d   = insert ? fill_q + FillW'(1) : fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (insert) begin
      entry_addr_q[fill_q[SlotW-1:0]] <= addr_i;
    end
  end

endmodule

/* rtl/core/psfca_queue.sv */
// Short command queue between the front end and the counter back end.
module psfca_queue
  import psfca_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PtrW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/psfca_back.sv */
// Back end: count read-modify-write, alarm check and result register.
module psfca_back
  import psfca_pkg::*;
#(
  parameter int TABLE_DEPTH = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  cmd_t             q_cmd_i,
  output logic             q_pop_o,
  input  logic [THR_W-1:0] thr_i,
  input  logic             beep_i,
  input  logic             res_pop_i,
  output logic             res_valid_o,
  output res_t             res_o
);

  localparam int SlotW = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int WideW = COUNT_BITS > OUT_COUNT_W ? COUNT_BITS : OUT_COUNT_W;

  back_state_e            state_q, state_d;
  cmd_t                   cmd_q;
  cmd_t                   cur;
  res_t                   res_q, res_d;
  logic                   res_valid_q, res_valid_d;
  logic                   res_free;
  logic                   cmd_ld, load;
  logic                   ram_re, ram_we;
  logic [SlotW-1:0]       ram_waddr;
  logic [COUNT_BITS-1:0]  ram_wdata, ram_rdata;
  logic [COUNT_BITS-1:0]  inc_cnt, cnt;
  logic [WideW-1:0]       cnt_wide;
  logic                   counted;

  assign res_free = !res_valid_q || res_pop_i;
  assign inc_cnt  = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_BITS'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i && (q_cmd_i.kind == CMD_HIT)) begin
          state_d = BK_READ;
        end
      end
      BK_READ: begin
        if (res_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // A table hit reads its count first; others wait only for the result register.
  always_comb begin
    q_pop_o   = 1'b0;
    cmd_ld    = 1'b0;
    load      = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = q_cmd_i.slot[SlotW-1:0];
    ram_wdata = COUNT_BITS'(1);
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (q_cmd_i.kind == CMD_HIT) begin
            q_pop_o = 1'b1;
            cmd_ld  = 1'b1;
            ram_re  = 1'b1;
          end else if (res_free) begin
            q_pop_o = 1'b1;
            load    = 1'b1;
            ram_we  = (q_cmd_i.kind == CMD_INSERT);
          end
        end
      end
      BK_READ: begin
        if (res_free) begin
          load      = 1'b1;
          ram_we    = 1'b1;
          ram_waddr = cmd_q.slot[SlotW-1:0];
          ram_wdata = inc_cnt;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cur     = (state_q == BK_READ) ? cmd_q : q_cmd_i;
    cnt     = '0;
    counted = 1'b0;
    res_d   = '0;
    res_d.addr = cur.addr;
    case (cur.kind)
      CMD_WL_HIT: res_d.wl_hit = 1'b1;
      CMD_HIT: begin
        cnt     = inc_cnt;
        counted = 1'b1;
      end
      CMD_INSERT: begin
        cnt             = COUNT_BITS'(1);
        counted         = 1'b1;
        res_d.new_entry = 1'b1;
      end
      CMD_FULL: res_d.full = 1'b1;
      default: ;
    endcase
    cnt_wide    = WideW'(cnt);
    res_d.count = (cnt_wide > WideW'({OUT_COUNT_W{1'b1}})) ?
                  {OUT_COUNT_W{1'b1}} : cnt_wide[OUT_COUNT_W-1:0];
    res_d.alarm = counted && (cnt_wide >= WideW'(thr_i));
    res_d.alert = res_d.alarm && beep_i;
  end

  assign res_valid_d = load ? 1'b1 : (res_pop_i ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_ld) begin
      cmd_q <= q_cmd_i;
    end
    if (load) begin
      res_q <= res_d;
    end
  end

  psfca_ram #(
    .Width (COUNT_BITS),
    .Depth (TABLE_DEPTH)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (q_cmd_i.slot[SlotW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* rtl/core/per_source_frame_count_alarm.sv */
// Per-source frame counter with threshold alarm: the top level.
// A whitelist, insert or table-full result passes the command queue and the
// result register; a repeat address also passes the count read and write-back.
// Throughput: one beat per cycle for whitelist, insert and full beats while
// results are popped; repeat addresses wait on the count read-modify-write.
// Reset empties the address table, the queue and the result register and loads
// the register defaults; no clearing pass runs.
module per_source_frame_count_alarm
  import psfca_pkg::*;
#(
  parameter int TABLE_DEPTH     = 16,
  parameter int WHITELIST_SLOTS = 4,
  parameter int COUNT_BITS      = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ADDR_W-1:0]      cfg_data_i,
  input  logic                   push,
  output logic                   full,
  input  logic [ADDR_W-1:0]      source_address_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [ADDR_W-1:0]      address_echo_o,
  output logic                   whitelisted_hit_o,
  output logic [OUT_COUNT_W-1:0] frame_count_o,
  output logic                   threshold_alarm_o,
  output logic                   audible_alert_o,
  output logic                   new_entry_o,
  output logic                   table_full_o
);

  logic [THR_W-1:0]              thr_q;
  logic [WL_USED_W-1:0]          wl_used_q;
  logic [WL_REGS-1:0][ADDR_W-1:0] wl_addr_q;
  logic                          beep_q;

  logic q_push, q_pop, q_full, q_empty;
  cmd_t front_cmd, q_cmd;
  res_t res;
  logic res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THR_W'(1);
      wl_used_q <= '0;
      wl_addr_q <= '0;
      beep_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_THRESHOLD: thr_q        <= cfg_data_i[THR_W-1:0];
        REG_WL_USED:   wl_used_q    <= cfg_data_i[WL_USED_W-1:0];
        REG_WL_A:      wl_addr_q[0] <= cfg_data_i;
        REG_WL_B:      wl_addr_q[1] <= cfg_data_i;
        REG_WL_C:      wl_addr_q[2] <= cfg_data_i;
        REG_WL_D:      wl_addr_q[3] <= cfg_data_i;
        REG_BEEP:      beep_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  psfca_front #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .WHITELIST_SLOTS (WHITELIST_SLOTS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .addr_i    (source_address_i),
    .q_full_i  (q_full),
    .wl_used_i (wl_used_q),
    .wl_addr_i (wl_addr_q),
    .q_push_o  (q_push),
    .cmd_o     (front_cmd)
  );

  psfca_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_cmd),
    .pop_i   (q_pop),
    .data_o  (q_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  psfca_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .thr_i       (thr_q),
    .beep_i      (beep_q),
    .res_pop_i   (pop && res_valid),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign full              = q_full;
  assign empty             = !res_valid;
  assign address_echo_o    = res.addr;
  assign whitelisted_hit_o = res.wl_hit;
  assign frame_count_o     = res.count;
  assign threshold_alarm_o = res.alarm;
  assign audible_alert_o   = res.alert;
  assign new_entry_o       = res.new_entry;
  assign table_full_o      = res.full;

  // A whitelist beat never carries any counting result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && whitelisted_hit_o) |->
      (frame_count_o == '0 && !threshold_alarm_o && !new_entry_o && !table_full_o))
    else $error("whitelist result carries count fields");

  // A freshly inserted address always reports a count of one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && new_entry_o) |-> (frame_count_o == OUT_COUNT_W'(1) && !table_full_o))
    else $error("new entry result has wrong count");

  // A rejected address is not counted and cannot alarm.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && table_full_o) |-> (frame_count_o == '0 && !threshold_alarm_o))
    else $error("table full result carries a count");

  // The audible alert follows the alarm and the beep enable.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && audible_alert_o) |-> (threshold_alarm_o && beep_q))
    else $error("audible alert without alarm and beep enable");

endmodule

/* test/per_source_frame_count_alarm_test.sv */
// Self-checking testbench for the per-source frame count alarm block.
module per_source_frame_count_alarm_test;
  import psfca_pkg::*;

  localparam int TBL_DEPTH  = 16;
  localparam int WL_SLOTS   = 4;
  localparam int CNT_BITS   = 16;
  localparam int CNT_LIMIT  = (1 << CNT_BITS) - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int ROUNDS     = 4;
  localparam int ROUND_BEATS = 160;
  localparam int HAMMER_BEATS = 48;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  typedef enum {ROW_FRAME, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    cfg_reg_e          idx;
    logic [ADDR_W-1:0] value;
    bit                typed;
    res_t              want;
  } script_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [ADDR_W-1:0]      cfg_data_i;
  logic                   push;
  logic                   full;
  logic [ADDR_W-1:0]      source_address_i;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [ADDR_W-1:0]      address_echo_o;
  logic                   whitelisted_hit_o;
  logic [OUT_COUNT_W-1:0] frame_count_o;
  logic                   threshold_alarm_o;
  logic                   audible_alert_o;
  logic                   new_entry_o;
  logic                   table_full_o;

  // Mirror of the registers and of the address table.
  logic [THR_W-1:0]     thr_now = 16'd1;
  logic [WL_USED_W-1:0] wl_count = '0;
  logic [ADDR_W-1:0]    wl_list[WL_SLOTS];
  logic                 beep_on = 1'b0;
  logic [ADDR_W-1:0]    src_addr[TBL_DEPTH];
  int unsigned          src_count[TBL_DEPTH];
  int unsigned          src_filled = 0;

  res_t        reports_due[$];
  script_row_t script[$];
  int          send_idle;
  int          recv_idle;
  int          mismatches = 0;
  int          results_seen = 0;
  int          stall_cycles = 0;
  bit          cfg_open = 1'b0;

  per_source_frame_count_alarm #(
    .TABLE_DEPTH    (TBL_DEPTH),
    .WHITELIST_SLOTS(WL_SLOTS),
    .COUNT_BITS     (CNT_BITS)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .source_address_i (source_address_i),
    .empty            (empty),
    .pop              (pop),
    .address_echo_o   (address_echo_o),
    .whitelisted_hit_o(whitelisted_hit_o),
    .frame_count_o    (frame_count_o),
    .threshold_alarm_o(threshold_alarm_o),
    .audible_alert_o  (audible_alert_o),
    .new_entry_o      (new_entry_o),
    .table_full_o     (table_full_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic res_t tally_frame(input logic [ADDR_W-1:0] a);
    res_t r;
    int   used;
    int   slot;
    bit   found;
    r = '0;
    r.addr = a;
    found = 1'b0;
    slot = 0;
    if (wl_count != 0) begin
      used = (wl_count > WL_SLOTS) ? WL_SLOTS : int'(wl_count);
      for (int i = 0; i < used; i++)
        if (wl_list[i] == a) r.wl_hit = 1'b1;
    end else begin
      for (int i = 0; i < src_filled; i++) begin
        if (!found && src_addr[i] == a) begin
          slot = i;
          found = 1'b1;
        end
      end
      if (found) begin
        if (src_count[slot] < CNT_LIMIT) src_count[slot]++;
      end else if (src_filled < TBL_DEPTH) begin
        slot = src_filled;
        src_addr[slot] = a;
        src_count[slot] = 1;
        src_filled++;
        r.new_entry = 1'b1;
        found = 1'b1;
      end else begin
        r.full = 1'b1;
      end
      if (found) begin
        r.count = (src_count[slot] > 65535) ? 16'hFFFF : src_count[slot][15:0];
        r.alarm = (src_count[slot] >= thr_now);
        r.alert = r.alarm & beep_on;
      end
    end
    return r;
  endfunction

  function automatic res_t mk_res(input logic [ADDR_W-1:0] a, input bit wl, input int cnt,
                                  input bit alarm, input bit alert, input bit fresh,
                                  input bit tfull);
    res_t r;
    r.addr = a;
    r.wl_hit = wl;
    r.count = cnt[15:0];
    r.alarm = alarm;
    r.alert = alert;
    r.new_entry = fresh;
    r.full = tfull;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ADDR_W-1:0] flip_bit(input logic [ADDR_W-1:0] a);
    return a ^ (48'd1 << $urandom_range(ADDR_W - 1));
  endfunction

  // Mostly repeat sources already in the table or on the whitelist, with near misses
  // and fresh addresses mixed in.
  function automatic logic [ADDR_W-1:0] pick_source(input bit wl_mode);
    int k;
    k = $urandom_range(99);
    if (wl_mode) begin
      if (k < 50) return wl_list[$urandom_range(WL_SLOTS - 1)];
      if (k < 65) return flip_bit(wl_list[$urandom_range(WL_SLOTS - 1)]);
      if (k < 80 && src_filled > 0) return src_addr[$urandom_range(src_filled - 1)];
      return rand_addr();
    end
    if (src_filled > 0) begin
      if (k < 60) return src_addr[$urandom_range(src_filled - 1)];
      if (k < 75) return flip_bit(src_addr[$urandom_range(src_filled - 1)]);
    end
    return rand_addr();
  endfunction

  task automatic report(input string field, input logic [ADDR_W-1:0] got,
                        input logic [ADDR_W-1:0] want);
    if (mismatches < 100)
      $display("result %0d: %0s is %h, expected %h", results_seen, field, got, want);
    mismatches++;
  endtask

  // Stops sending and waits until every result owed has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [ADDR_W-1:0] value);
    if (!cfg_open) wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      REG_THRESHOLD: thr_now = value[THR_W-1:0];
      REG_WL_USED:   wl_count = value[WL_USED_W-1:0];
      REG_WL_A:      wl_list[0] = value;
      REG_WL_B:      wl_list[1] = value;
      REG_WL_C:      wl_list[2] = value;
      REG_WL_D:      wl_list[3] = value;
      REG_BEEP:      beep_on = value[0];
      default: ;
    endcase
    cfg_open = 1'b1;
    @(negedge clk_i);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_frame(input logic [ADDR_W-1:0] a, input bit typed, input res_t want);
    res_t due;
    if (cfg_open) begin
      cfg_we_i <= 1'b0;
      cfg_open = 1'b0;
    end
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    source_address_i <= a;
    do @(posedge clk_i); while (full);
    due = tally_frame(a);
    if (typed) due = want;
    reports_due = {reports_due, due};
    @(negedge clk_i);
  endtask

  task automatic add_frame(input logic [ADDR_W-1:0] a);
    script_row_t row;
    row = '{ROW_FRAME, REG_THRESHOLD, a, 1'b0, res_t'('0)};
    script = {script, row};
  endtask

  task automatic add_checked(input res_t want);
    script_row_t row;
    row = '{ROW_FRAME, REG_THRESHOLD, want.addr, 1'b1, want};
    script = {script, row};
  endtask

  task automatic add_write(input cfg_reg_e idx, input logic [ADDR_W-1:0] value);
    script_row_t row;
    row = '{ROW_WRITE, idx, value, 1'b0, res_t'('0)};
    script = {script, row};
  endtask

  task automatic random_round(input int round);
    bit wl_mode;
    wl_mode = round[0];
    case ($urandom_range(5))
      0:       write_reg(REG_THRESHOLD, 48'd0);
      1:       write_reg(REG_THRESHOLD, 48'd1);
      2:       write_reg(REG_THRESHOLD, 48'hFFFF);
      3:       write_reg(REG_THRESHOLD, 48'($urandom_range(16'hFFFF)));
      default: write_reg(REG_THRESHOLD, 48'($urandom_range(40, 2)));
    endcase
    write_reg(REG_BEEP, 48'($urandom_range(1)));
    if (wl_mode) begin
      for (int i = 0; i < WL_SLOTS; i++) begin
        case ($urandom_range(9))
          0:       write_reg(cfg_reg_e'(REG_WL_A + i), ALL_ONES);
          1:       write_reg(cfg_reg_e'(REG_WL_A + i), 48'd0);
          2:       write_reg(cfg_reg_e'(REG_WL_A + i),
                             src_addr[$urandom_range(src_filled - 1)]);
          default: write_reg(cfg_reg_e'(REG_WL_A + i), rand_addr());
        endcase
      end
      write_reg(REG_WL_USED, 48'($urandom_range(7, 1)));
    end else begin
      write_reg(REG_WL_USED, 48'd0);
    end
    for (int n = 0; n < ROUND_BEATS; n++) begin
      // Hold the sender back once per round until the block has drained.
      if (n == ROUND_BEATS / 2) wait_drained();
      send_frame(pick_source(wl_mode), 1'b0, res_t'('0));
    end
  endtask

  always @(negedge clk_i) pop <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (reports_due.size() == 0) begin
        report("unexpected result address", address_echo_o, '0);
      end else begin
        res_t want;
        want = reports_due.pop_front();
        if (address_echo_o !== want.addr) report("address_echo", address_echo_o, want.addr);
        if (whitelisted_hit_o !== want.wl_hit)
          report("whitelisted_hit", 48'(whitelisted_hit_o), 48'(want.wl_hit));
        if (frame_count_o !== want.count)
          report("frame_count", 48'(frame_count_o), 48'(want.count));
        if (threshold_alarm_o !== want.alarm)
          report("threshold_alarm", 48'(threshold_alarm_o), 48'(want.alarm));
        if (audible_alert_o !== want.alert)
          report("audible_alert", 48'(audible_alert_o), 48'(want.alert));
        if (new_entry_o !== want.new_entry)
          report("new_entry", 48'(new_entry_o), 48'(want.new_entry));
        if (table_full_o !== want.full)
          report("table_full", 48'(table_full_o), 48'(want.full));
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_THRESHOLD;
    cfg_data_i = '0;
    push = 1'b0;
    source_address_i = '0;
    send_idle = 15;
    recv_idle = 55;
    for (int i = 0; i < WL_SLOTS; i++) wl_list[i] = '0;
    for (int i = 0; i < TBL_DEPTH; i++) begin
      src_addr[i] = '0;
      src_count[i] = 0;
    end

    // Counting mode from reset: threshold 1, no beep.
    add_checked(mk_res(48'd0, 0, 1, 1, 0, 1, 0));
    add_checked(mk_res(ALL_ONES, 0, 1, 1, 0, 1, 0));
    add_frame(48'd0);
    // A zero threshold alarms on every counted frame.
    add_write(REG_THRESHOLD, 48'd0);
    add_write(REG_BEEP, 48'd1);
    add_frame(48'd0);
    add_write(REG_THRESHOLD, 48'hFFFF);
    add_frame(ALL_ONES);
    add_frame(48'd1);
    // Whitelist mode with one slot, then too many slots, then all four.
    add_write(REG_WL_A, 48'h0123_4567_89AB);
    add_write(REG_WL_B, 48'h8000_0000_0000);
    add_write(REG_WL_C, 48'h7FFF_FFFF_FFFF);
    add_write(REG_WL_D, ALL_ONES);
    add_write(REG_WL_USED, 48'd1);
    add_checked(mk_res(48'h0123_4567_89AB, 1, 0, 0, 0, 0, 0));
    add_checked(mk_res(48'h8000_0000_0000, 0, 0, 0, 0, 0, 0));
    add_checked(mk_res(48'd0, 0, 0, 0, 0, 0, 0));
    add_write(REG_WL_USED, 48'd7);
    add_checked(mk_res(ALL_ONES, 1, 0, 0, 0, 0, 0));
    add_checked(mk_res(48'h0123_4567_89AA, 0, 0, 0, 0, 0, 0));
    add_write(REG_WL_USED, 48'd4);
    add_checked(mk_res(48'h7FFF_FFFF_FFFF, 1, 0, 0, 0, 0, 0));
    add_write(REG_WL_USED, 48'd0);
    add_write(REG_THRESHOLD, 48'd3);
    add_frame(48'd0);
    add_frame(48'h8000_0000_0000);
    add_frame(48'h8000_0000_0000);

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) write_reg(script[i].idx, script[i].value);
      else send_frame(script[i].value, script[i].typed, script[i].want);
    end

    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        send_idle = 55;
        recv_idle = 15;
      end else if (p == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int r = 0; r < ROUNDS; r++) random_round(r);
    end

    // Hammer one source back to back with the beep enabled and a top threshold.
    write_reg(REG_WL_USED, 48'd0);
    write_reg(REG_THRESHOLD, 48'hFFFF);
    write_reg(REG_BEEP, 48'd1);
    for (int n = 0; n < HAMMER_BEATS; n++) send_frame(src_addr[0], 1'b0, res_t'('0));

    push <= 1'b0;
    cfg_we_i <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (reports_due.size() != 0) report("results still owed", 48'(reports_due.size()), '0);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
rtl/core/psfca_pkg.sv
rtl/core/psfca_ram.sv
rtl/core/psfca_front.sv
rtl/core/psfca_queue.sv
rtl/core/psfca_back.sv
rtl/core/per_source_frame_count_alarm.sv
test/per_source_frame_count_alarm_test.sv
